// ----- hdl/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg: shared types, constants and functions of the BinHex stream encoder
// Holds the command codes, the 64-entry symbol table and the CRC-16 step.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  // Command codes carried on the input tuser
  localparam logic [1:0] OP_DATA   = 2'd0;
  localparam logic [1:0] OP_CRC    = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_START  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_NL_LENGTH = 2'd0;
  localparam logic [1:0] REG_NL_FIRST  = 2'd1;
  localparam logic [1:0] REG_NL_SECOND = 2'd2;

  // Register reset values
  localparam logic [1:0] NL_LENGTH_RESET = 2'd2;
  localparam logic [7:0] NL_FIRST_RESET  = 8'd13;
  localparam logic [7:0] NL_SECOND_RESET = 8'd10;

  // Fixed characters and codes
  localparam logic [7:0]  ESC_BYTE   = 8'h90;
  localparam logic [7:0]  COLON_CHAR = 8'h3a;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  // At most this many characters per command leave the block
  localparam int unsigned MAX_CHARS = 8;

  // Defaults for the top-level parameters
  localparam int unsigned LINE_WIDTH_DEFAULT  = 64;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // 6-bit group to text character
  localparam logic [7:0] SYM_TABLE [64] = '{
    8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h40, 8'h41,
    8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h50, 8'h51, 8'h52,
    8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5a, 8'h5b,
    8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
    8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h70, 8'h71, 8'h72
  };

  // Classified command, front to back
  typedef struct packed {
    logic [1:0] op;
    logic       esc;
    logic [7:0] data_byte;
  } cmd_t;

  // Line terminator settings
  typedef struct packed {
    logic [1:0] length;
    logic [7:0] first;
    logic [7:0] second;
  } nl_cfg_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic busy;
    logic crc_prep;
  } back_status_t;

  function automatic logic [7:0] sym_char(input logic [5:0] idx);
    return SYM_TABLE[idx];
  endfunction

  // One byte through the zero-augmented CRC-16, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] t;
    logic [7:0]  c;
    t = crc;
    c = b;
    for (int i = 0; i < 8; i++) begin
      t = {t[14:0], 1'b0} ^ (t[15] ? CRC_POLY : 16'h0000) ^ {15'b0, c[7]};
      c = {c[6:0], 1'b0};
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/binhex_stream_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// binhex_stream_encoder_unit: BinHex 4.0 character stream generator
// Turns start, data byte, CRC and finish commands into BinHex text.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser is the command (0 data byte, 1 emit CRC,
//   2 finish, 3 start), tdata the byte for data commands. m_axis carries one
//   text character per transfer; tlast marks the final character of a command.
//   The cfg port sets the line terminator (length, first, second byte); write
//   it only while the block is idle.
//   The CRC command first runs two zero bytes through the CRC for the zero
//   augmentation. Throughput: the sequencer emits one character per cycle
//   while m_axis is ready, with no gap between commands (a data byte makes
//   1 to 5 characters, on average about 1.4). A command queue in front lets
//   new commands enter while the sequencer works.
//   Reset clears the encoder state (line count 1, CRC 0) and the registers
//   return to CR LF. When m_axis stalls, the output register holds and the
//   sequencer waits; s_axis_tready drops once the command queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module binhex_stream_encoder_unit
  import bse_pkg::*;
#(
  parameter int unsigned LINE_WIDTH  = LINE_WIDTH_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0] s_axis_tuser,   // [1:0] op
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] encoded_char
  output logic            m_axis_tlast,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wr_data
);

  nl_cfg_t      nl_cfg;
  logic         q_valid;
  logic         q_ready;
  cmd_t         q_cmd;
  back_status_t back_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nl_cfg.length <= NL_LENGTH_RESET;
      nl_cfg.first  <= NL_FIRST_RESET;
      nl_cfg.second <= NL_SECOND_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NL_LENGTH: nl_cfg.length <= cfg_wr_data[1:0];
        REG_NL_FIRST:  nl_cfg.first  <= cfg_wr_data;
        REG_NL_SECOND: nl_cfg.second <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Command intake and queue
  bse_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  // Character sequencer
  bse_back #(
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .nl_cfg    (nl_cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .status    (back_status)
  );

`ifndef ASSERT_OFF
  // A full queue always has a command to offer
  a_full_has_cmd: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("queue full but nothing offered to sequencer");

  // An idle sequencer takes a waiting command at once
  a_idle_takes: assert property (@(posedge clk) disable iff (rst)
    q_valid && !back_status.busy |-> q_ready)
    else $error("idle sequencer left a command waiting");

  // No output transfer right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // CRC preparation never pulls a new command
  a_crc_no_take: assert property (@(posedge clk) disable iff (rst)
    back_status.crc_prep |-> !q_ready)
    else $error("command taken during CRC preparation");
`endif

endmodule

`default_nettype wire

// ----- hdl/bse_front.sv -----
// ----------------------------------------------------------------------------
// bse_front: command intake and queue
// Accepts input transfers, classifies them and holds them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_front
  import bse_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_data,
  output logic            q_valid,
  input  wire logic       q_ready,
  output cmd_t            q_cmd
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  cmd_t             cmd_in;
  logic             push;
  logic             pop;

  // Classify the incoming command
  always_comb begin
    cmd_in.op        = in_op;
    cmd_in.esc       = (in_data == ESC_BYTE);
    cmd_in.data_byte = in_data;
  end

  assign in_ready = (count != FULL_CNT);
  assign q_valid  = (count != '0);
  assign q_cmd    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bse_back.sv -----
// ----------------------------------------------------------------------------
// bse_back: character sequencer
// Runs one command at a time, one output character per cycle when not stalled,
// via the 8-to-6 packer, line breaker and CRC, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_back
  import bse_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire nl_cfg_t    nl_cfg,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire cmd_t       q_cmd,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last,
  output back_status_t    status
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CRC  = 3'd1;
  localparam logic [2:0] ST_BODY = 3'd2;
  localparam logic [2:0] ST_TERM = 3'd3;
  localparam logic [2:0] ST_TAIL = 3'd4;

  localparam logic [6:0] LW7       = 7'(LINE_WIDTH);
  localparam logic [3:0] CHAR_CAP  = 4'(MAX_CHARS);
  localparam logic [3:0] CHAR_LAST = 4'(MAX_CHARS - 1);

  // Control state
  logic [2:0]  st, st_next;
  logic        crc_pre, crc_pre_next;
  logic        sub, sub_next;
  logic        term_pos, term_pos_next;
  logic        has_tail, has_tail_next;
  logic        tail_term, tail_term_next;
  logic        tok_feed, tok_feed_next;
  logic [2:0]  tok_cnt, tok_cnt_next;
  logic [3:0]  nchar, nchar_next;
  logic [1:0]  phase, phase_next;
  logic [5:0]  saved, saved_next;
  logic [6:0]  line_count, line_count_next;
  logic [15:0] crc, crc_next;
  logic        o_valid, o_valid_next;

  // Payload
  logic [7:0]  tok [4];
  logic [7:0]  tok_next [4];
  logic [7:0]  o_char, o_char_next;
  logic        o_last, o_last_next;

  // Per-cycle decode
  logic        nl_any, nl_two;
  logic        emit_ok, silent, adv, has_char, more, item_end, take;
  logic [7:0]  char_val;
  logic [7:0]  cur_byte;
  logic [5:0]  sym_idx;
  logic        tok_done;
  logic [1:0]  pk_phase;
  logic [5:0]  pk_saved;
  logic [6:0]  lc_inc;
  logic        line_end, term_after, body_more, term_more, body_rem;
  logic [15:0] crc_aug;
  logic        esc_hi, esc_lo;

  assign nl_any = (nl_cfg.length != 2'd0);
  assign nl_two = nl_cfg.length[1];

  assign cur_byte = tok[0];
  assign lc_inc   = line_count + 7'd1;
  assign line_end = (lc_inc == LW7);

  // 8-to-6 packing of the head token
  always_comb begin
    case (phase)
      2'd1: begin
        sym_idx  = saved | {2'b00, cur_byte[7:4]};
        tok_done = 1'b1;
        pk_phase = 2'd2;
        pk_saved = {cur_byte[3:0], 2'b00};
      end
      2'd2: begin
        if (!sub) begin
          sym_idx  = saved | {4'b0000, cur_byte[7:6]};
          tok_done = 1'b0;
          pk_phase = phase;
          pk_saved = saved;
        end else begin
          sym_idx  = cur_byte[5:0];
          tok_done = 1'b1;
          pk_phase = 2'd0;
          pk_saved = 6'd0;
        end
      end
      default: begin
        sym_idx  = cur_byte[7:2];
        tok_done = 1'b1;
        pk_phase = 2'd1;
        pk_saved = {cur_byte[1:0], 4'b0000};
      end
    endcase
  end

  // Sequencer next state
  always_comb begin
    st_next         = st;
    crc_pre_next    = crc_pre;
    sub_next        = sub;
    term_pos_next   = term_pos;
    has_tail_next   = has_tail;
    tail_term_next  = tail_term;
    tok_feed_next   = tok_feed;
    tok_cnt_next    = tok_cnt;
    tok_next        = tok;
    nchar_next      = nchar;
    phase_next      = phase;
    saved_next      = saved;
    line_count_next = line_count;
    crc_next        = crc;
    o_valid_next    = o_valid && !out_ready;
    o_char_next     = o_char;
    o_last_next     = o_last;

    emit_ok    = !o_valid || out_ready;
    silent     = (nchar == CHAR_CAP);
    has_char   = 1'b0;
    adv        = 1'b0;
    more       = 1'b0;
    char_val   = COLON_CHAR;
    term_after = line_end && nl_any;
    body_more  = !tok_done || (tok_cnt > 3'd1);
    term_more  = !term_pos && nl_two;
    body_rem   = (tok_cnt != 3'd0);
    crc_aug    = crc_feed(crc, 8'h00);
    esc_hi     = (crc_aug[15:8] == ESC_BYTE);
    esc_lo     = (crc_aug[7:0] == ESC_BYTE);

    case (st)
      // Two zero bytes into the CRC, then queue its bytes as tokens
      ST_CRC: begin
        adv = 1'b1;
        if (!crc_pre) begin
          crc_next     = crc_aug;
          crc_pre_next = 1'b1;
        end else begin
          tok_next[0]   = crc_aug[15:8];
          tok_next[1]   = esc_hi ? 8'h00 : crc_aug[7:0];
          tok_next[2]   = esc_hi ? crc_aug[7:0] : 8'h00;
          tok_next[3]   = 8'h00;
          tok_cnt_next  = 3'd2 + {2'b00, esc_hi} + {2'b00, esc_lo};
          tok_feed_next = 1'b0;
          crc_next      = 16'h0000;
          sub_next      = 1'b0;
          st_next       = ST_BODY;
        end
      end

      // One table symbol
      ST_BODY: begin
        has_char = 1'b1;
        adv      = silent || emit_ok;
        char_val = sym_char(sym_idx);
        more     = term_after || body_more || has_tail;
        if (adv) begin
          phase_next      = pk_phase;
          saved_next      = pk_saved;
          sub_next        = (phase == 2'd2) && !sub;
          line_count_next = line_end ? 7'd0 : lc_inc;
          if (tok_done) begin
            tok_next[0]   = tok[1];
            tok_next[1]   = tok[2];
            tok_next[2]   = tok[3];
            tok_cnt_next  = tok_cnt - 3'd1;
            tok_feed_next = 1'b0;
            if (tok_feed) begin
              crc_next = crc_feed(crc, cur_byte);
            end
          end
          term_pos_next = 1'b0;
          if (term_after) begin
            st_next = ST_TERM;
          end else if (body_more) begin
            st_next = ST_BODY;
          end else if (has_tail) begin
            st_next = ST_TAIL;
          end else begin
            st_next = ST_IDLE;
          end
        end
      end

      // Line terminator bytes
      ST_TERM: begin
        has_char = 1'b1;
        adv      = silent || emit_ok;
        char_val = term_pos ? nl_cfg.second : nl_cfg.first;
        more     = term_more || body_rem || has_tail;
        if (adv) begin
          if (term_more) begin
            term_pos_next = 1'b1;
          end else begin
            term_pos_next = 1'b0;
            if (body_rem) begin
              st_next = ST_BODY;
            end else if (has_tail) begin
              st_next = ST_TAIL;
            end else begin
              st_next = ST_IDLE;
            end
          end
        end
      end

      // Closing or opening colon
      ST_TAIL: begin
        has_char = 1'b1;
        adv      = silent || emit_ok;
        char_val = COLON_CHAR;
        more     = tail_term && nl_any;
        if (adv) begin
          has_tail_next = 1'b0;
          term_pos_next = 1'b0;
          st_next       = more ? ST_TERM : ST_IDLE;
        end
      end

      default: begin
        st_next = ST_IDLE;
      end
    endcase

    // Output register write, last flag also closes a capped command
    if (adv && has_char && !silent) begin
      o_valid_next = 1'b1;
      o_char_next  = char_val;
      o_last_next  = !more || (nchar == CHAR_LAST);
      nchar_next   = nchar + 4'd1;
    end

    item_end = adv && has_char && !more;
    take     = q_valid && ((st == ST_IDLE) || item_end);

    // Load the next command
    if (take) begin
      nchar_next     = 4'd0;
      term_pos_next  = 1'b0;
      sub_next       = 1'b0;
      crc_pre_next   = 1'b0;
      has_tail_next  = 1'b0;
      tail_term_next = 1'b0;
      tok_feed_next  = 1'b1;
      case (q_cmd.op)
        OP_DATA: begin
          tok_next[0]  = q_cmd.data_byte;
          tok_next[1]  = 8'h00;
          tok_cnt_next = q_cmd.esc ? 3'd2 : 3'd1;
          st_next      = ST_BODY;
        end
        OP_CRC: begin
          st_next = ST_CRC;
        end
        OP_FINISH: begin
          tail_term_next = 1'b1;
          if (phase_next != 2'd0) begin
            tok_next[0]   = 8'h00;
            tok_cnt_next  = 3'd1;
            has_tail_next = 1'b1;
            st_next       = ST_BODY;
          end else begin
            st_next = ST_TAIL;
          end
        end
        default: begin
          phase_next      = 2'd0;
          saved_next      = 6'd0;
          line_count_next = 7'd1;
          crc_next        = 16'h0000;
          st_next         = ST_TAIL;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      crc_pre    <= 1'b0;
      sub        <= 1'b0;
      term_pos   <= 1'b0;
      has_tail   <= 1'b0;
      tail_term  <= 1'b0;
      tok_feed   <= 1'b0;
      tok_cnt    <= 3'd0;
      nchar      <= 4'd0;
      phase      <= 2'd0;
      saved      <= 6'd0;
      line_count <= 7'd1;
      crc        <= 16'h0000;
      o_valid    <= 1'b0;
    end else begin
      st         <= st_next;
      crc_pre    <= crc_pre_next;
      sub        <= sub_next;
      term_pos   <= term_pos_next;
      has_tail   <= has_tail_next;
      tail_term  <= tail_term_next;
      tok_feed   <= tok_feed_next;
      tok_cnt    <= tok_cnt_next;
      nchar      <= nchar_next;
      phase      <= phase_next;
      saved      <= saved_next;
      line_count <= line_count_next;
      crc        <= crc_next;
      o_valid    <= o_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tok    <= tok_next;
    o_char <= o_char_next;
    o_last <= o_last_next;
  end

  assign q_ready         = take;
  assign out_valid       = o_valid;
  assign out_char        = o_char;
  assign out_last        = o_last;
  assign status.busy     = (st != ST_IDLE);
  assign status.crc_prep = (st == ST_CRC);

endmodule

`default_nettype wire
